/* hw/rtl/sos_pkg.sv */
`default_nettype none

package sos_pkg;

	localparam int MAX_PATTERN_DEF = 64;
	localparam int INDEX_BITS_DEF  = 32;
	localparam int SYMBOL_W        = 8;
	localparam int MATCH_START_W   = 32;

	localparam logic CMD_PATTERN = 1'b0;
	localparam logic CMD_TEXT    = 1'b1;

	typedef struct packed {
		logic                cmd;
		logic [SYMBOL_W-1:0] symbol;
		logic                first;
	} item_t;

	typedef struct packed {
		logic [MATCH_START_W-1:0] match_start;
	} result_t;

	// write request into the pattern store
	typedef struct packed {
		logic                en;
		logic [SYMBOL_W-1:0] symbol;
	} pat_wr_t;

endpackage

`default_nettype wire

/* hw/rtl/sos_stream_if.sv */
`default_nettype none

interface sos_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/sos_pat_store.sv */
`default_nettype none

module sos_pat_store import sos_pkg::*; #(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF,
	parameter int AW          = 6
) (
	input  wire logic                   clk,
	input  wire pat_wr_t                wr,
	input  wire logic [AW-1:0]          wr_addr,
	input  wire logic [SYMBOL_W-1:0]    symbol,
	output logic      [MAX_PATTERN-1:0] miss_mask
);

	logic [SYMBOL_W-1:0] bytes_q [MAX_PATTERN];

	// one byte lane per entry, written by address decode
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (wr.en && wr_addr == AW'(i)) begin
				bytes_q[i] <= wr.symbol;
			end
		end
	end

	// bit clear where the stored byte equals the text byte
	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			miss_mask[i] = (bytes_q[i] != symbol);
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/shift_or_string_matcher.sv */
`default_nettype none

// channel  | dir | payload                     | note
// item     | in  | cmd, symbol[7:0], first     | pattern byte (cmd 0) or text byte (cmd 1)
// result   | out | match_start[31:0]           | start index of a completed match
//
// one beat per cycle while result is not stalled; an item passes the input register,
// then the result register; the rate is set by the shift-or update on the state vector
// arst_n clears pattern length, overflow mark, text index and all valids;
// the match vector resets to all ones, pattern bytes stay undefined
// a stalled result holds the pipe; the input register still takes a beat when
// it is empty, and frees as soon as the result register can take its outcome

module shift_or_string_matcher import sos_pkg::*; #(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF,
	parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	sos_stream_if.sink   item,
	sos_stream_if.source result
);

	localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int CW = $clog2(MAX_PATTERN + 1);
	localparam int EW = (INDEX_BITS > MATCH_START_W) ? INDEX_BITS : MATCH_START_W;

	// input register
	logic  valid_s1;
	item_t item_s1;

	// block state
	logic [MAX_PATTERN-1:0] match_vec_q;
	logic [CW-1:0]          pat_count_q;
	logic                   pat_ovf_q;
	logic [INDEX_BITS-1:0]  idx_q;

	// result register
	logic                     res_valid_q;
	logic [MATCH_START_W-1:0] res_start_q;

	logic adv_s1;
	logic do_item;

	// pattern side
	logic [CW-1:0] count_base;
	logic          ovf_base;
	logic          store_full;
	pat_wr_t       pat_wr;
	logic [AW-1:0] pat_wr_addr;

	// text side
	logic [MAX_PATTERN-1:0] miss_mask;
	logic [MAX_PATTERN-1:0] vec_base;
	logic [MAX_PATTERN-1:0] vec_next;
	logic [INDEX_BITS-1:0]  idx_base;
	logic [INDEX_BITS-1:0]  start_idx;
	logic [EW-1:0]          start_ext;
	logic [AW-1:0]          tap_sel;
	logic                   hit;

	// the s1 item moves on whenever the result register is free or being drained
	assign adv_s1     = !res_valid_q || result.ready;
	assign do_item    = adv_s1 && valid_s1;
	assign item.ready = !valid_s1 || adv_s1;

	// new pattern restarts the store at entry zero
	assign count_base  = item_s1.first ? '0 : pat_count_q;
	assign ovf_base    = item_s1.first ? 1'b0 : pat_ovf_q;
	assign store_full  = (count_base == CW'(MAX_PATTERN));
	assign pat_wr_addr = count_base[AW-1:0];

	always_comb begin
		pat_wr.en     = do_item && item_s1.cmd == CMD_PATTERN && !store_full;
		pat_wr.symbol = item_s1.symbol;
	end

	sos_pat_store #(
		.MAX_PATTERN (MAX_PATTERN),
		.AW          (AW)
	) u_store (
		.clk       (clk),
		.wr        (pat_wr),
		.wr_addr   (pat_wr_addr),
		.symbol    (item_s1.symbol),
		.miss_mask (miss_mask)
	);

	// shift-or step; bits above the pattern length never reach the tap
	assign vec_base = item_s1.first ? '1 : match_vec_q;
	assign idx_base = item_s1.first ? '0 : idx_q;
	assign vec_next = (vec_base << 1) | miss_mask;

	assign tap_sel   = AW'(pat_count_q - CW'(1));
	assign hit       = (pat_count_q != '0) && !pat_ovf_q && !vec_next[tap_sel];
	assign start_idx = idx_base - INDEX_BITS'(pat_count_q) + INDEX_BITS'(1);
	assign start_ext = EW'(start_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready) begin
			item_s1 <= item.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_vec_q <= '1;
			pat_count_q <= '0;
			pat_ovf_q   <= 1'b0;
			idx_q       <= '0;
		end else if (do_item) begin
			if (item_s1.cmd == CMD_PATTERN) begin
				match_vec_q <= '1;
				if (store_full) begin
					pat_count_q <= count_base;
					pat_ovf_q   <= 1'b1;
				end else begin
					pat_count_q <= count_base + CW'(1);
					pat_ovf_q   <= ovf_base;
				end
			end else begin
				match_vec_q <= vec_next;
				idx_q       <= idx_base + INDEX_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1) begin
			res_valid_q <= valid_s1 && item_s1.cmd == CMD_TEXT && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_start_q <= start_ext[MATCH_START_W-1:0];
		end
	end

	assign result.valid            = res_valid_q;
	assign result.data.match_start = res_start_q;

`ifndef SYNTH
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		pat_count_q <= CW'(MAX_PATTERN))
		else $error("pattern length beyond store depth");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		pat_ovf_q |-> pat_count_q == CW'(MAX_PATTERN))
		else $error("overflow mark set with store not full");

	a_pat_resets_vec: assert property (@(posedge clk) disable iff (!arst_n)
		do_item && item_s1.cmd == CMD_PATTERN |=> &match_vec_q)
		else $error("pattern byte left match vector dirty");

	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		do_item && item_s1.cmd == CMD_TEXT && !item_s1.first
		|=> idx_q == $past(idx_q) + INDEX_BITS'(1))
		else $error("text index did not advance by one");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !result.ready |=> res_valid_q && $stable(res_start_q))
		else $error("stalled result lost");
`endif

endmodule

`default_nettype wire
